[design/trc_pkg.sv]
// Shared constants and types for the thermostat relay controller.
package trc_pkg;

   localparam int ReadingWidth  = 11;
   localparam int TempWidth     = 11;
   localparam int SetPointWidth = 10;
   localparam int BandWidth     = 5;
   localparam int OffsetWidth   = 6;
   localparam int ModeWidth     = 2;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 10;

   typedef logic [ModeWidth-1:0]     mode_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   typedef logic [TempWidth-1:0]     temp_type;

   // operating modes
   localparam mode_type ModeThermometer = 2'd0;
   localparam mode_type ModeThermostat  = 2'd1;
   localparam mode_type ModeThermofuse  = 2'd2;
   localparam mode_type ModeIdle        = 2'd3;

   // register indexes
   localparam csr_index_type CsrMode     = 2'd0;
   localparam csr_index_type CsrSetPoint = 2'd1;
   localparam csr_index_type CsrBand     = 2'd2;
   localparam csr_index_type CsrOffset   = 2'd3;

   // reset values
   localparam mode_type                 ModeReset     = ModeThermostat;
   localparam logic [SetPointWidth-1:0] SetPointReset = 10'd50;
   localparam logic [BandWidth-1:0]     BandReset     = 5'd5;
   localparam logic [OffsetWidth-1:0]   OffsetReset   = 6'd0;
   localparam temp_type                 PeakReset     = 11'd0;
   localparam temp_type                 LowestReset   = 11'd1000;

endpackage

[design/thermostat_relay_controller.sv]
// Thermostat relay controller: reading correction, peak/low tracking and relay mode logic.
//
// Takes one signed whole-degree reading per request and returns one result per request.
// A negative reading is a sensor fault: relay off, corrected temperature zero, and the
// peak, lowest, over-temperature latch and LED hold. A good reading gets the calibration
// offset added and is clamped at zero, then updates peak and lowest and runs the mode
// logic (thermometer, thermostat with hysteresis, latching thermofuse; mode 3 idles with
// the relay off). A request is captured in an input register and its result, along with
// the new state, is written to the output register when that register is free. A request
// can be taken every cycle while the result channel does not stall; the state feedback
// loops through the compare logic. Configuration writes are expected only while idle.
module thermostat_relay_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [trc_pkg::ReadingWidth-1:0] req_reading,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [trc_pkg::TempWidth-1:0]          rsp_corrected_temp,
   output logic                                   rsp_relay_on,
   output logic                                   rsp_high_temp_led,
   output logic                                   rsp_fault_led,
   output logic [trc_pkg::TempWidth-1:0]          rsp_peak_temp,
   output logic [trc_pkg::TempWidth-1:0]          rsp_lowest_temp,
   output logic                                   rsp_overtemp_flag,
   // configuration
   input  logic                                   csr_write,
   input  logic [trc_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [trc_pkg::CsrDataWidth-1:0]       csr_wdata
);

   // configuration registers
   trc_pkg::mode_type                         mode_ff;
   logic [trc_pkg::SetPointWidth-1:0]         set_point_ff;
   logic [trc_pkg::BandWidth-1:0]             band_ff;
   logic [trc_pkg::OffsetWidth-1:0]           offset_ff;

   // input stage
   logic                                      in_valid_ff, in_valid_in;
   logic [trc_pkg::ReadingWidth-1:0]          in_reading_ff;

   // controller state
   trc_pkg::temp_type                         peak_ff, peak_in;
   trc_pkg::temp_type                         lowest_ff, lowest_in;
   logic                                      overtemp_ff, overtemp_in;
   logic                                      indicator_ff, indicator_in;

   // output stage
   logic                                      rsp_valid_ff, rsp_valid_in;
   trc_pkg::temp_type                         rsp_temp_ff;
   logic                                      rsp_relay_ff, rsp_fault_ff;

   logic                                      out_ready;
   logic                                      stage_fire;
   logic                                      fault;
   logic signed [trc_pkg::ReadingWidth:0]     sum;
   trc_pkg::temp_type                         corr;
   logic [trc_pkg::ReadingWidth:0]            sp_ext;
   logic signed [trc_pkg::ReadingWidth:0]     threshold;
   logic                                      le_sp, lt_sp, le_thr;
   logic                                      relay;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= trc_pkg::ModeReset;
         set_point_ff <= trc_pkg::SetPointReset;
         band_ff      <= trc_pkg::BandReset;
         offset_ff    <= trc_pkg::OffsetReset;
      end else if (csr_write) begin
         unique case (csr_index)
            trc_pkg::CsrMode:     mode_ff      <= csr_wdata[trc_pkg::ModeWidth-1:0];
            trc_pkg::CsrSetPoint: set_point_ff <= csr_wdata[trc_pkg::SetPointWidth-1:0];
            trc_pkg::CsrBand:     band_ff      <= csr_wdata[trc_pkg::BandWidth-1:0];
            trc_pkg::CsrOffset:   offset_ff    <= csr_wdata[trc_pkg::OffsetWidth-1:0];
         endcase
      end
   end

   // handshake: output register frees when empty or being taken
   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign stage_fire  = in_valid_ff && out_ready;
   assign req_stall   = in_valid_ff && !out_ready;
   assign in_valid_in = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = out_ready ? in_valid_ff : 1'b1;

   // correction and compares
   assign fault = in_reading_ff[trc_pkg::ReadingWidth-1];
   assign sum = $signed({in_reading_ff[trc_pkg::ReadingWidth-1], in_reading_ff})
              + $signed({{(trc_pkg::ReadingWidth + 1 - trc_pkg::OffsetWidth)
                          {offset_ff[trc_pkg::OffsetWidth-1]}}, offset_ff});
   assign corr = (!fault && !sum[trc_pkg::ReadingWidth]) ?
                 sum[trc_pkg::TempWidth-1:0] : '0;
   assign sp_ext = {{(trc_pkg::ReadingWidth + 1 - trc_pkg::SetPointWidth){1'b0}},
                    set_point_ff};
   assign threshold = $signed(sp_ext)
                    - $signed({{(trc_pkg::ReadingWidth + 1 - trc_pkg::BandWidth){1'b0}},
                               band_ff});
   assign le_sp  = {1'b0, corr} <= sp_ext;
   assign lt_sp  = {1'b0, corr} <  sp_ext;
   assign le_thr = $signed({1'b0, corr}) <= threshold;

   always_comb begin
      peak_in      = peak_ff;
      lowest_in    = lowest_ff;
      overtemp_in  = overtemp_ff;
      indicator_in = indicator_ff;
      relay        = 1'b0;
      if (!fault) begin
         if (peak_ff < corr) peak_in = corr;
         if (lowest_ff > corr) lowest_in = corr;
         unique case (mode_ff)
            trc_pkg::ModeThermometer: begin
               indicator_in = 1'b0;
            end
            trc_pkg::ModeThermostat: begin
               if ((le_sp && !overtemp_ff) || le_thr) begin
                  relay       = 1'b1;
                  overtemp_in = 1'b0;
               end else begin
                  overtemp_in = 1'b1;
               end
               indicator_in = !le_sp;
            end
            trc_pkg::ModeThermofuse: begin
               if (!overtemp_ff && lt_sp) begin
                  relay = 1'b1;
               end else begin
                  overtemp_in  = 1'b1;
                  indicator_in = 1'b1;
               end
            end
            trc_pkg::ModeIdle: begin
               relay = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         peak_ff      <= trc_pkg::PeakReset;
         lowest_ff    <= trc_pkg::LowestReset;
         overtemp_ff  <= 1'b0;
         indicator_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (stage_fire) begin
            peak_ff      <= peak_in;
            lowest_ff    <= lowest_in;
            overtemp_ff  <= overtemp_in;
            indicator_ff <= indicator_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) in_reading_ff <= req_reading;
      if (stage_fire) begin
         rsp_temp_ff  <= corr;
         rsp_relay_ff <= relay;
         rsp_fault_ff <= fault;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_corrected_temp = rsp_temp_ff;
   assign rsp_relay_on       = rsp_relay_ff;
   assign rsp_fault_led      = rsp_fault_ff;
   assign rsp_high_temp_led  = indicator_ff;
   assign rsp_peak_temp      = peak_ff;
   assign rsp_lowest_temp    = lowest_ff;
   assign rsp_overtemp_flag  = overtemp_ff;

`ifndef SYNTHESIS
   a_fault_relay_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault_led |-> !rsp_relay_on && rsp_corrected_temp == '0)
      else $error("fault result with relay on or nonzero temperature");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> peak_ff >= $past(peak_ff))
      else $error("peak temperature decreased");

   a_lowest_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> lowest_ff <= $past(lowest_ff))
      else $error("lowest temperature increased");

   a_state_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !stage_fire |=> $stable(peak_ff) && $stable(lowest_ff) && $stable(overtemp_ff))
      else $error("state changed without a request completing");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("request stalled with room in the pipe");
`endif

endmodule
